@@ rtl/triangle_basis_shape_and_gradient_assert.svh @@
// Assertion macros for the triangle basis shape and gradient block.
// Used by the port checker; needs nothing else.
`ifndef TRIANGLE_BASIS_SHAPE_AND_GRADIENT_ASSERT_SVH
`define TRIANGLE_BASIS_SHAPE_AND_GRADIENT_ASSERT_SVH

// Check cons in the same cycle as ante.
`define TBSG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define TBSG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tbsg_pkg.sv @@
// Shared types and constants for the triangle basis shape and gradient block.
// No dependencies.
`default_nettype none

package tbsg_pkg;

  localparam int Q_W       = 32;
  localparam int Q_FRAC    = 24;
  localparam int PROD_W    = 2 * Q_W;
  localparam int RND_W     = PROD_W - Q_FRAC;
  localparam int DOF_W     = 6;
  localparam int ADDR_W    = 16;
  localparam int NODE_W    = 3;
  localparam int POINT_W   = 10;
  localparam int ORDER_W   = 3;
  localparam int STRIDE_W  = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 6;
  localparam int IN_DATA_W  = 208;
  localparam int OUT_DATA_W = 120;

  localparam logic [CFG_IDX_W-1:0] CFG_ORDER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 2'd1;

  typedef struct packed {
    logic store;
    logic start;
    logic fetch;
    logic mul1;
    logic diff;
    logic mul2;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic last_dof;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/tbsg_ctrl.sv @@
// Sequencer for the triangle basis block: load, then five steps per result.
// Depends on tbsg_pkg for the command and status structs.
`default_nettype none

module tbsg_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  input  wire logic          in_tlast,
  output logic               in_tready,
  input  wire tbsg_pkg::sts_t sts,
  output tbsg_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_MUL1  = 3'd2;
  localparam logic [2:0] S_DIFF  = 3'd3;
  localparam logic [2:0] S_MUL2  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cmd.store = accept;
    cmd.start = accept && in_tlast;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.start) state_nxt = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.last_dof ? S_IDLE : S_FETCH;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/tbsg_dp.sv @@
// Datapath: node stores, index walk, shared multipliers, Q8.24 rounding and output register.
// Depends on tbsg_pkg; driven by tbsg_ctrl commands.
`default_nettype none

module tbsg_dp #(
  parameter int MAX_ORDER = 7
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire tbsg_pkg::cmd_t                     cmd,
  output tbsg_pkg::sts_t                          sts,
  input  wire logic                               cfg_wr_en,
  input  wire logic [tbsg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tbsg_pkg::CFG_DAT_W-1:0]     cfg_wdata,
  input  wire logic [tbsg_pkg::NODE_W-1:0]        node_index,
  input  wire logic [tbsg_pkg::POINT_W-1:0]       point_index,
  input  wire logic signed [tbsg_pkg::Q_W-1:0]    x_value,
  input  wire logic signed [tbsg_pkg::Q_W-1:0]    y_value,
  input  wire logic signed [tbsg_pkg::Q_W-1:0]    l_value,
  input  wire logic signed [tbsg_pkg::Q_W-1:0]    x_slope,
  input  wire logic signed [tbsg_pkg::Q_W-1:0]    y_slope,
  input  wire logic signed [tbsg_pkg::Q_W-1:0]    l_slope,
  input  wire logic                               out_tready,
  output logic                                    out_valid,
  output logic [tbsg_pkg::DOF_W-1:0]              out_dof,
  output logic [tbsg_pkg::ADDR_W-1:0]             out_addr,
  output logic signed [tbsg_pkg::Q_W-1:0]         out_shape,
  output logic signed [tbsg_pkg::Q_W-1:0]         out_gx,
  output logic signed [tbsg_pkg::Q_W-1:0]         out_gy,
  output logic                                    out_last
);

  localparam int DEPTH = MAX_ORDER + 1;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QW    = tbsg_pkg::Q_W;
  localparam int PW    = tbsg_pkg::PROD_W;
  localparam int RW    = tbsg_pkg::RND_W;
  localparam logic signed [PW-1:0] RND_HALF = PW'(64'sd1 <<< (tbsg_pkg::Q_FRAC - 1));
  localparam logic signed [RW:0]   SAT_MAX  = (RW+1)'((64'sd1 <<< (QW - 1)) - 64'sd1);
  localparam logic signed [RW:0]   SAT_MIN  = (RW+1)'(-(64'sd1 <<< (QW - 1)));

  function automatic logic signed [RW-1:0] q_round(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] w;
    w = v + RND_HALF;
    return w[PW-1:tbsg_pkg::Q_FRAC];
  endfunction

  function automatic logic signed [QW-1:0] q_sat(input logic signed [RW:0] v);
    logic signed [QW-1:0] r;
    if (v > SAT_MAX)      r = SAT_MAX[QW-1:0];
    else if (v < SAT_MIN) r = SAT_MIN[QW-1:0];
    else                  r = v[QW-1:0];
    return r;
  endfunction

  function automatic logic signed [RW:0] q_ext(input logic signed [RW-1:0] v);
    return {v[RW-1], v};
  endfunction

  logic signed [QW-1:0] x_store_r  [DEPTH];
  logic signed [QW-1:0] y_store_r  [DEPTH];
  logic signed [QW-1:0] l_store_r  [DEPTH];
  logic signed [QW-1:0] xs_store_r [DEPTH];
  logic signed [QW-1:0] ys_store_r [DEPTH];
  logic signed [QW-1:0] ls_store_r [DEPTH];

  logic [tbsg_pkg::ORDER_W-1:0]  order_r;
  logic [tbsg_pkg::STRIDE_W-1:0] stride_r;
  logic [IW-1:0]                 p_r, i_r, j_r, k_idx;
  logic [tbsg_pkg::DOF_W-1:0]    o_r;
  logic [tbsg_pkg::ADDR_W-1:0]   base_r;
  logic                          row_end;

  logic signed [QW-1:0] xa_r, ya_r, la_r, dxa_r, dya_r, dla_r;
  logic signed [QW-1:0] xyq_r, gxd_r, gyd_r;
  logic signed [PW-1:0] m0_r, m1_r, m2_r, m3_r, m4_r;
  logic signed [QW-1:0] a0, b0, a1, b1, a2, b2;
  logic signed [PW-1:0] prod0, prod1, prod2, prod3, prod4;
  logic                 out_valid_r;

  logic [tbsg_pkg::DOF_W-1:0]  out_dof_r;
  logic [tbsg_pkg::ADDR_W-1:0] out_addr_r;
  logic signed [QW-1:0]        out_shape_r, out_gx_r, out_gy_r;
  logic                        out_last_r;

  assign k_idx   = p_r - i_r - j_r;
  assign row_end = ((IW+1)'(i_r) + (IW+1)'(j_r)) == (IW+1)'(p_r);
  assign sts.last_dof = row_end && (j_r == p_r);
  assign sts.out_free = !out_valid_r || out_tready;
  assign out_valid    = out_valid_r;
  assign out_dof      = out_dof_r;
  assign out_addr     = out_addr_r;
  assign out_shape    = out_shape_r;
  assign out_gx       = out_gx_r;
  assign out_gy       = out_gy_r;
  assign out_last     = out_last_r;

  // node stores
  always_ff @(posedge clk) begin
    if (cmd.store && (32'(node_index) <= MAX_ORDER)) begin
      x_store_r[IW'(node_index)]  <= x_value;
      y_store_r[IW'(node_index)]  <= y_value;
      l_store_r[IW'(node_index)]  <= l_value;
      xs_store_r[IW'(node_index)] <= x_slope;
      ys_store_r[IW'(node_index)] <= y_slope;
      ls_store_r[IW'(node_index)] <= l_slope;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r  <= tbsg_pkg::ORDER_W'(1);
      stride_r <= tbsg_pkg::STRIDE_W'(36);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tbsg_pkg::CFG_ORDER:  order_r  <= cfg_wdata[tbsg_pkg::ORDER_W-1:0];
        tbsg_pkg::CFG_STRIDE: stride_r <= cfg_wdata[tbsg_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // index walk: j outer, i inner, k = p - i - j
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= '0;
      i_r <= '0;
      j_r <= '0;
      o_r <= '0;
    end else if (cmd.start) begin
      p_r <= (32'(order_r) > MAX_ORDER) ? IW'(MAX_ORDER) : IW'(order_r);
      i_r <= '0;
      j_r <= '0;
      o_r <= '0;
    end else if (cmd.emit) begin
      o_r <= o_r + 1'b1;
      if (!sts.last_dof) begin
        if (row_end) begin
          j_r <= j_r + 1'b1;
          i_r <= '0;
        end else begin
          i_r <= i_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      base_r <= tbsg_pkg::ADDR_W'(point_index) * tbsg_pkg::ADDR_W'(stride_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      xa_r  <= x_store_r[i_r];
      ya_r  <= y_store_r[j_r];
      la_r  <= l_store_r[k_idx];
      dxa_r <= xs_store_r[i_r];
      dya_r <= ys_store_r[j_r];
      dla_r <= ls_store_r[k_idx];
    end
  end

  // shared multipliers: first pass forms the five raw products, second the three finals
  always_comb begin
    a0 = cmd.mul2 ? xyq_r : xa_r;
    b0 = cmd.mul2 ? la_r  : ya_r;
    a1 = cmd.mul2 ? gxd_r : dxa_r;
    b1 = cmd.mul2 ? ya_r  : la_r;
    a2 = cmd.mul2 ? gyd_r : xa_r;
    b2 = cmd.mul2 ? xa_r  : dla_r;
  end

  assign prod0 = a0 * b0;
  assign prod1 = a1 * b1;
  assign prod2 = a2 * b2;
  assign prod3 = dya_r * la_r;
  assign prod4 = ya_r * dla_r;

  always_ff @(posedge clk) begin
    if (cmd.mul1 || cmd.mul2) begin
      m0_r <= prod0;
      m1_r <= prod1;
      m2_r <= prod2;
    end
    if (cmd.mul1) begin
      m3_r <= prod3;
      m4_r <= prod4;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      xyq_r <= q_sat(q_ext(q_round(m0_r)));
      gxd_r <= q_sat(q_ext(q_round(m1_r)) - q_ext(q_round(m2_r)));
      gyd_r <= q_sat(q_ext(q_round(m3_r)) - q_ext(q_round(m4_r)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_dof_r   <= o_r;
      out_addr_r  <= base_r + tbsg_pkg::ADDR_W'(o_r);
      out_shape_r <= q_sat(q_ext(q_round(m0_r)));
      out_gx_r    <= q_sat(q_ext(q_round(m1_r)));
      out_gy_r    <= q_sat(q_ext(q_round(m2_r)));
      out_last_r  <= sts.last_dof;
    end
  end

endmodule

`default_nettype wire

@@ rtl/triangle_basis_shape_and_gradient.sv @@
// Top level of the triangle basis shape and gradient block.
// Depends on tbsg_pkg, tbsg_ctrl and tbsg_dp.
//
// channel | dir | tdata (low bit up)                                  | tlast
// in_     | in  | node_index, point_index, x_value, y_value, l_value, | last_node
//         |     | x_slope, y_slope, l_slope                           |
// out_    | out | dof_index, value_address, shape_value, grad_x,      | last_of_run
//         |     | grad_y                                              |
// cfg_    | in  | write enable, register index, write data            | -
//
// Node items load the stores. After the item with tlast, each result runs through
// store read, raw product pass, round and difference, final product pass and output
// load, on three shared and two dedicated 32x32 multipliers; a run at order p gives
// (p+1)*(p+2)/2 results. in_tready is high only when no run is active. A stalled
// out_tready holds the run at the output load step. Reset sets order to 1 and
// row_stride to 36; stores hold garbage until loaded.
`default_nettype none

module triangle_basis_shape_and_gradient #(
  parameter int MAX_ORDER = 7
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // node_index, point_index, x_value, y_value, l_value, x_slope, y_slope, l_slope, pad
  input  wire logic [tbsg_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire logic                                in_tlast,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // dof_index, value_address, shape_value, grad_x, grad_y, pad
  output logic [tbsg_pkg::OUT_DATA_W-1:0]          out_tdata,
  output logic                                     out_tlast,
  input  wire logic                                cfg_wr_en,
  input  wire logic [tbsg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tbsg_pkg::CFG_DAT_W-1:0]      cfg_wdata
);

  tbsg_pkg::cmd_t cmd;
  tbsg_pkg::sts_t sts;

  logic [tbsg_pkg::DOF_W-1:0]          out_dof;
  logic [tbsg_pkg::ADDR_W-1:0]         out_addr;
  logic signed [tbsg_pkg::Q_W-1:0]     out_shape, out_gx, out_gy;

  tbsg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tbsg_dp #(
    .MAX_ORDER (MAX_ORDER)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .node_index  (in_tdata[2:0]),
    .point_index (in_tdata[12:3]),
    .x_value     (in_tdata[44:13]),
    .y_value     (in_tdata[76:45]),
    .l_value     (in_tdata[108:77]),
    .x_slope     (in_tdata[140:109]),
    .y_slope     (in_tdata[172:141]),
    .l_slope     (in_tdata[204:173]),
    .out_tready  (out_tready),
    .out_valid   (out_tvalid),
    .out_dof     (out_dof),
    .out_addr    (out_addr),
    .out_shape   (out_shape),
    .out_gx      (out_gx),
    .out_gy      (out_gy),
    .out_last    (out_tlast)
  );

  assign out_tdata = {2'b00, out_gy, out_gx, out_shape, out_addr, out_dof};

endmodule

`default_nettype wire

@@ rtl/tbsg_chk.sv @@
// Port checker for the triangle basis shape and gradient block, bound to the top level.
// Depends on triangle_basis_shape_and_gradient_assert.svh and tbsg_pkg.
`default_nettype none

`include "triangle_basis_shape_and_gradient_assert.svh"

module tbsg_chk (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tvalid,
  input wire logic                               in_tready,
  input wire logic                               in_tlast,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [tbsg_pkg::OUT_DATA_W-1:0]    out_tdata,
  input wire logic                               out_tlast
);

  `TBSG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled output item changed")
  `TBSG_ASSERT_SAME(a_busy_mid_run, clk, rst_n, out_tvalid && !out_tlast, !in_tready, "input taken while a run is still open")
  `TBSG_ASSERT_NEXT(a_start_busy, clk, rst_n, in_tvalid && in_tready && in_tlast, !in_tready, "input still ready after a run start")

endmodule

bind triangle_basis_shape_and_gradient tbsg_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
